@@ rtl/core/rssi_to_distance_interpolator_top_defines.svh @@
// ----------------------------------------------------------------------------
// RSSI to distance interpolator: assertion macros
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RSSI_TO_DISTANCE_INTERPOLATOR_TOP_DEFINES_SVH
`define RSSI_TO_DISTANCE_INTERPOLATOR_TOP_DEFINES_SVH

// Check a condition that must hold in the same cycle
`define RTID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a condition that must hold in the cycle after a trigger
`define RTID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/rtid_pkg.sv @@
// ----------------------------------------------------------------------------
// rtid_pkg
// Calibration ROM, field widths and pipeline payload types for the
// RSSI to distance interpolator.
// ----------------------------------------------------------------------------
package rtid_pkg;

  // Calibration points and derived index width
  localparam int TABLE_POINTS = 26;
  localparam int SEG_W        = $clog2(TABLE_POINTS - 1);

  // Field widths
  localparam int RSSI_W  = 16;
  localparam int DIST_W  = 16;
  localparam int WHOLE_W = 13;
  localparam int CFG_W   = 13;

  // Segment arithmetic widths, sized for the calibration points below
  // (widest RSSI span 738, largest distance step 100)
  localparam int SPAN_W  = 10;
  localparam int DELTA_W = 7;
  localparam int Q_W     = 7;
  localparam int NUM_W   = SPAN_W + DELTA_W;

  // Far distance scaling
  localparam int FAR_W     = CFG_W + 4;
  localparam int FAR_SCALE = 10;

  // Rounding to whole cm: (d + 5) / 10 by reciprocal multiply
  localparam int RND_W       = DIST_W + 1;
  localparam int ROUND_HALF  = 5;
  localparam int RECIP_W     = 16;
  localparam int RECIP_10    = 52429;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = RND_W + RECIP_W;

  localparam logic [CFG_W-1:0] FAR_CM_RESET = CFG_W'(200);

  typedef struct packed {
    logic [DIST_W-1:0] dist_x10;
    logic [RSSI_W-1:0] rssi;
  } cal_point_t;

  // Ordered by falling RSSI (twice raw scale) and rising distance (0.1 cm)
  localparam cal_point_t CAL_ROM [TABLE_POINTS] = '{
    '{16'd90,   16'd5762}, '{16'd140,  16'd5024}, '{16'd190,  16'd4498},
    '{16'd240,  16'd4248}, '{16'd290,  16'd4172}, '{16'd340,  16'd3602},
    '{16'd390,  16'd3420}, '{16'd440,  16'd3260}, '{16'd490,  16'd3102},
    '{16'd540,  16'd2966}, '{16'd590,  16'd2854}, '{16'd640,  16'd2280},
    '{16'd690,  16'd2160}, '{16'd740,  16'd2050}, '{16'd790,  16'd1960},
    '{16'd840,  16'd1880}, '{16'd890,  16'd1800}, '{16'd990,  16'd1672},
    '{16'd1090, 16'd1554}, '{16'd1190, 16'd1460}, '{16'd1290, 16'd1388},
    '{16'd1390, 16'd1320}, '{16'd1490, 16'd1260}, '{16'd1590, 16'd1200},
    '{16'd1690, 16'd1160}, '{16'd1790, 16'd1120}
  };

  typedef enum logic [1:0] {
    STATUS_VALID = 2'd0,
    STATUS_NEAR  = 2'd1,
    STATUS_FAR   = 2'd2
  } range_status_t;

  // After classification
  typedef struct packed {
    logic [RSSI_W-1:0] x2;
    range_status_t     status;
    logic [SEG_W-1:0]  seg;
    logic              nohit;
    logic [DIST_W-1:0] far_dist;
  } cls_t;

  // After segment lookup
  typedef struct packed {
    logic [DIST_W-1:0]  base;
    logic [SPAN_W-1:0]  diff;
    logic [DELTA_W-1:0] delta;
    logic [SPAN_W-1:0]  span;
    logic               zero;
    range_status_t      status;
  } seg_t;

  // Divider working set
  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [SPAN_W-1:0] span;
    logic [Q_W-1:0]    q;
    logic [DIST_W-1:0] base;
    range_status_t     status;
  } div_t;

endpackage

@@ rtl/core/rtid_classify.sv @@
// ----------------------------------------------------------------------------
// rtid_classify
// First stage: doubles the sample, classifies it against the table ends,
// finds the first bracketing segment and scales the far distance.
// ----------------------------------------------------------------------------
module rtid_classify (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_stall,
  input  logic [rtid_pkg::RSSI_W-1:0]    rssi_sample,
  input  logic [rtid_pkg::CFG_W-1:0]     far_cm,
  output logic                           dn_valid,
  input  logic                           dn_stall,
  output rtid_pkg::cls_t                 dn_data
);

  logic           v_r;
  rtid_pkg::cls_t d_r;
  rtid_pkg::cls_t d_nxt;
  logic           stall;

  // Classify and search all segments in parallel, first hit wins
  always_comb begin
    logic [rtid_pkg::RSSI_W-1:0] x2;
    logic [rtid_pkg::SEG_W-1:0]  seg;
    logic                        hit;
    logic [rtid_pkg::FAR_W-1:0]  far;
    x2  = {rssi_sample[rtid_pkg::RSSI_W-2:0], 1'b0};
    seg = '0;
    hit = 1'b0;
    for (int i = rtid_pkg::TABLE_POINTS - 2; i >= 0; i--) begin
      if (x2 <= rtid_pkg::CAL_ROM[i].rssi && x2 >= rtid_pkg::CAL_ROM[i+1].rssi) begin
        seg = rtid_pkg::SEG_W'(i);
        hit = 1'b1;
      end
    end
    far = rtid_pkg::FAR_W'(far_cm) * rtid_pkg::FAR_W'(rtid_pkg::FAR_SCALE);

    d_nxt.x2    = x2;
    d_nxt.seg   = seg;
    d_nxt.nohit = !hit;
    if (x2 > rtid_pkg::CAL_ROM[0].rssi) begin
      d_nxt.status = rtid_pkg::STATUS_NEAR;
    end else if (x2 < rtid_pkg::CAL_ROM[rtid_pkg::TABLE_POINTS-1].rssi) begin
      d_nxt.status = rtid_pkg::STATUS_FAR;
    end else begin
      d_nxt.status = rtid_pkg::STATUS_VALID;
    end
    // Saturate the far distance at the output range
    if (far[rtid_pkg::FAR_W-1:rtid_pkg::DIST_W] != '0) begin
      d_nxt.far_dist = '1;
    end else begin
      d_nxt.far_dist = far[rtid_pkg::DIST_W-1:0];
    end
  end

  // Hold while the next stage is stalled and this stage is full
  assign stall    = v_r && dn_stall;
  assign up_stall = stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!stall) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule

@@ rtl/core/rtid_segment.sv @@
// ----------------------------------------------------------------------------
// rtid_segment
// Two stages: segment end lookup with differences, then the numerator
// product with the rounding half span added.
// ----------------------------------------------------------------------------
module rtid_segment (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_stall,
  input  rtid_pkg::cls_t up_data,
  output logic           dn_valid,
  input  logic           dn_stall,
  output rtid_pkg::div_t dn_data
);

  logic           lk_v_r;
  rtid_pkg::seg_t lk_r;
  rtid_pkg::seg_t lk_nxt;
  logic           lk_stall;
  logic           mu_v_r;
  rtid_pkg::div_t mu_r;
  rtid_pkg::div_t mu_nxt;
  logic           mu_stall;

  // Look up the segment ends and form the differences
  always_comb begin
    logic [rtid_pkg::SEG_W-1:0]  seg_p1;
    logic [rtid_pkg::RSSI_W-1:0] hi;
    logic [rtid_pkg::RSSI_W-1:0] lo;
    logic [rtid_pkg::DIST_W-1:0] d0;
    logic [rtid_pkg::DIST_W-1:0] d1;
    logic [rtid_pkg::RSSI_W-1:0] span;
    logic [rtid_pkg::RSSI_W-1:0] diff;
    logic [rtid_pkg::DIST_W-1:0] delta;
    seg_p1 = up_data.seg + rtid_pkg::SEG_W'(1);
    hi     = rtid_pkg::CAL_ROM[up_data.seg].rssi;
    lo     = rtid_pkg::CAL_ROM[seg_p1].rssi;
    d0     = rtid_pkg::CAL_ROM[up_data.seg].dist_x10;
    d1     = rtid_pkg::CAL_ROM[seg_p1].dist_x10;
    span   = hi - lo;
    diff   = hi - up_data.x2;
    delta  = d1 - d0;

    lk_nxt.diff   = diff[rtid_pkg::SPAN_W-1:0];
    lk_nxt.span   = span[rtid_pkg::SPAN_W-1:0];
    lk_nxt.delta  = delta[rtid_pkg::DELTA_W-1:0];
    lk_nxt.status = up_data.status;
    // Clamped results and flat segments take the base distance as is
    lk_nxt.zero   = (up_data.status != rtid_pkg::STATUS_VALID) || up_data.nohit ||
                    (span == '0);
    if (up_data.status == rtid_pkg::STATUS_NEAR) begin
      lk_nxt.base = rtid_pkg::CAL_ROM[0].dist_x10;
    end else if (up_data.status == rtid_pkg::STATUS_FAR) begin
      lk_nxt.base = up_data.far_dist;
    end else if (up_data.nohit) begin
      lk_nxt.base = rtid_pkg::CAL_ROM[rtid_pkg::TABLE_POINTS-1].dist_x10;
    end else begin
      lk_nxt.base = d0;
    end
  end

  // Multiply offset by distance step, add half span for rounding
  always_comb begin
    logic [rtid_pkg::NUM_W-1:0] prod;
    prod = rtid_pkg::NUM_W'(lk_r.diff) * rtid_pkg::NUM_W'(lk_r.delta);
    mu_nxt.q      = '0;
    mu_nxt.base   = lk_r.base;
    mu_nxt.status = lk_r.status;
    if (lk_r.zero) begin
      mu_nxt.rem  = '0;
      mu_nxt.span = rtid_pkg::SPAN_W'(1);
    end else begin
      mu_nxt.rem  = prod + rtid_pkg::NUM_W'(lk_r.span >> 1);
      mu_nxt.span = lk_r.span;
    end
  end

  // Stall chain, back to front
  assign mu_stall = mu_v_r && dn_stall;
  assign lk_stall = lk_v_r && mu_stall;
  assign up_stall = lk_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_v_r <= 1'b0;
      mu_v_r <= 1'b0;
    end else begin
      if (!lk_stall) begin
        lk_v_r <= up_valid;
      end
      if (!mu_stall) begin
        mu_v_r <= lk_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!lk_stall) begin
      lk_r <= lk_nxt;
    end
    if (!mu_stall) begin
      mu_r <= mu_nxt;
    end
  end

  assign dn_valid = mu_v_r;
  assign dn_data  = mu_r;

endmodule

@@ rtl/core/rtid_divider.sv @@
// ----------------------------------------------------------------------------
// rtid_divider
// Pipelined restoring divider: one quotient bit per stage, numerator by
// segment span, most significant bit first.
// ----------------------------------------------------------------------------
module rtid_divider (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_stall,
  input  rtid_pkg::div_t up_data,
  output logic           dn_valid,
  input  logic           dn_stall,
  output rtid_pkg::div_t dn_data
);

  logic           v_r     [rtid_pkg::Q_W];
  rtid_pkg::div_t d_r     [rtid_pkg::Q_W];
  rtid_pkg::div_t d_nxt   [rtid_pkg::Q_W];
  logic           stg_v   [rtid_pkg::Q_W];
  rtid_pkg::div_t stg_d   [rtid_pkg::Q_W];
  logic           stall   [rtid_pkg::Q_W];

  for (genvar k = 0; k < rtid_pkg::Q_W; k++) begin : g_stage
    localparam int BIT = rtid_pkg::Q_W - 1 - k;

    // Select the stage input and the downstream stall
    if (k == 0) begin : g_first
      assign stg_v[k] = up_valid;
      assign stg_d[k] = up_data;
    end else begin : g_next
      assign stg_v[k] = v_r[k-1];
      assign stg_d[k] = d_r[k-1];
    end

    if (k == rtid_pkg::Q_W - 1) begin : g_last
      assign stall[k] = v_r[k] && dn_stall;
    end else begin : g_mid
      assign stall[k] = v_r[k] && stall[k+1];
    end

    // Trial subtract of the shifted divisor
    always_comb begin
      logic [rtid_pkg::NUM_W-1:0] trial;
      trial    = rtid_pkg::NUM_W'(stg_d[k].span) << BIT;
      d_nxt[k] = stg_d[k];
      if (stg_d[k].rem >= trial) begin
        d_nxt[k].rem    = stg_d[k].rem - trial;
        d_nxt[k].q[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (!stall[k]) begin
        v_r[k] <= stg_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!stall[k]) begin
        d_r[k] <= d_nxt[k];
      end
    end
  end

  assign up_stall = stall[0];
  assign dn_valid = v_r[rtid_pkg::Q_W-1];
  assign dn_data  = d_r[rtid_pkg::Q_W-1];

endmodule

@@ rtl/core/rtid_finish.sv @@
// ----------------------------------------------------------------------------
// rtid_finish
// Two stages: add the quotient to the base distance, then round to whole
// centimetres by reciprocal multiply into the output register.
// ----------------------------------------------------------------------------
module rtid_finish (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_stall,
  input  rtid_pkg::div_t                 up_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rtid_pkg::DIST_W-1:0]    out_distance_tenth_cm,
  output logic [rtid_pkg::WHOLE_W-1:0]   out_distance_whole_cm,
  output logic [1:0]                     out_range_status,
  output logic                           out_in_calibration
);

  logic                          ad_v_r;
  logic [rtid_pkg::DIST_W-1:0]   ad_dist_r;
  logic [rtid_pkg::DIST_W-1:0]   ad_dist_nxt;
  logic [rtid_pkg::RND_W-1:0]    ad_rnd_r;
  logic [rtid_pkg::RND_W-1:0]    ad_rnd_nxt;
  rtid_pkg::range_status_t       ad_status_r;
  logic                          ad_stall;
  logic                          ot_v_r;
  logic [rtid_pkg::DIST_W-1:0]   ot_dist_r;
  logic [rtid_pkg::WHOLE_W-1:0]  ot_whole_r;
  logic [rtid_pkg::WHOLE_W-1:0]  ot_whole_nxt;
  rtid_pkg::range_status_t       ot_status_r;
  logic                          ot_stall;
  logic [rtid_pkg::PROD_W-1:0]   prod;

  // Final distance and the rounding offset
  assign ad_dist_nxt = up_data.base + rtid_pkg::DIST_W'(up_data.q);
  assign ad_rnd_nxt  = rtid_pkg::RND_W'(ad_dist_nxt) + rtid_pkg::RND_W'(rtid_pkg::ROUND_HALF);

  // Divide by ten through the reciprocal
  assign prod         = rtid_pkg::PROD_W'(ad_rnd_r) * rtid_pkg::PROD_W'(rtid_pkg::RECIP_10);
  assign ot_whole_nxt = prod[rtid_pkg::RECIP_SHIFT +: rtid_pkg::WHOLE_W];

  // Stall chain, back to front
  assign ot_stall = ot_v_r && out_stall;
  assign ad_stall = ad_v_r && ot_stall;
  assign up_stall = ad_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ad_v_r <= 1'b0;
      ot_v_r <= 1'b0;
    end else begin
      if (!ad_stall) begin
        ad_v_r <= up_valid;
      end
      if (!ot_stall) begin
        ot_v_r <= ad_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ad_stall) begin
      ad_dist_r   <= ad_dist_nxt;
      ad_rnd_r    <= ad_rnd_nxt;
      ad_status_r <= up_data.status;
    end
    if (!ot_stall) begin
      ot_dist_r   <= ad_dist_r;
      ot_whole_r  <= ot_whole_nxt;
      ot_status_r <= ad_status_r;
    end
  end

  assign out_valid             = ot_v_r;
  assign out_distance_tenth_cm = ot_dist_r;
  assign out_distance_whole_cm = ot_whole_r;
  assign out_range_status      = ot_status_r;
  assign out_in_calibration    = (ot_status_r == rtid_pkg::STATUS_VALID);

endmodule

@@ rtl/core/rssi_to_distance_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// rssi_to_distance_interpolator_top
// RSSI sample to distance by piecewise linear interpolation over a fixed
// calibration ROM, with too-near and too-far clamping.
// ----------------------------------------------------------------------------
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------
//   in       | in_valid / in_stall | rssi_sample
//   out      | out_valid/out_stall | distance_tenth_cm, distance_whole_cm,
//            |                     | range_status, in_calibration
//   cfg      | cfg_wr_en           | cfg_wr_data (too_far_distance_cm)
//
// Throughput is one item per cycle while out_stall is low; the stages are classify,
// lookup, multiply, 7 divider stages (one quotient bit each), add, round.
// Reset clears every stage valid bit and loads the far distance with 200 cm.
// A stall freezes only full stages; empty stages keep filling, so
// in_stall rises only when every stage holds an item and out_stall is high.
// ----------------------------------------------------------------------------
`include "rssi_to_distance_interpolator_top_defines.svh"

module rssi_to_distance_interpolator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rtid_pkg::RSSI_W-1:0]    in_rssi_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rtid_pkg::DIST_W-1:0]    out_distance_tenth_cm,
  output logic [rtid_pkg::WHOLE_W-1:0]   out_distance_whole_cm,
  output logic [1:0]                     out_range_status,
  output logic                           out_in_calibration,
  input  logic                           cfg_wr_en,
  input  logic [rtid_pkg::CFG_W-1:0]     cfg_wr_data
);

  logic [rtid_pkg::CFG_W-1:0] far_cm_r;
  logic                       cls_valid;
  logic                       cls_stall;
  rtid_pkg::cls_t             cls_data;
  logic                       seg_valid;
  logic                       seg_stall;
  rtid_pkg::div_t             seg_data;
  logic                       div_valid;
  logic                       div_stall;
  rtid_pkg::div_t             div_data;

  // Far distance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_cm_r <= rtid_pkg::FAR_CM_RESET;
    end else if (cfg_wr_en) begin
      far_cm_r <= cfg_wr_data;
    end
  end

  rtid_classify u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (in_valid),
    .up_stall    (in_stall),
    .rssi_sample (in_rssi_sample),
    .far_cm      (far_cm_r),
    .dn_valid    (cls_valid),
    .dn_stall    (cls_stall),
    .dn_data     (cls_data)
  );

  rtid_segment u_segment (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cls_valid),
    .up_stall (cls_stall),
    .up_data  (cls_data),
    .dn_valid (seg_valid),
    .dn_stall (seg_stall),
    .dn_data  (seg_data)
  );

  rtid_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (seg_valid),
    .up_stall (seg_stall),
    .up_data  (seg_data),
    .dn_valid (div_valid),
    .dn_stall (div_stall),
    .dn_data  (div_data)
  );

  rtid_finish u_finish (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .up_valid              (div_valid),
    .up_stall              (div_stall),
    .up_data               (div_data),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_distance_tenth_cm (out_distance_tenth_cm),
    .out_distance_whole_cm (out_distance_whole_cm),
    .out_range_status      (out_range_status),
    .out_in_calibration    (out_in_calibration)
  );

  // Input backpressure only comes from a stalled output
  `RTID_ASSERT(a_stall_origin, !in_stall || (out_valid && out_stall), "input stalled without output stall")

  // Valid flag follows the status code
  `RTID_ASSERT(a_calib_flag, !out_valid || (out_in_calibration == (out_range_status == rtid_pkg::STATUS_VALID)), "in_calibration disagrees with range_status")

  // Too-near results carry the first table distance
  `RTID_ASSERT(a_near_dist, !(out_valid && out_range_status == rtid_pkg::STATUS_NEAR) || (out_distance_tenth_cm == rtid_pkg::CAL_ROM[0].dist_x10), "too-near distance wrong")

  // Whole cm is the tenth-cm value rounded half up
  `RTID_ASSERT(a_round, !out_valid || ((32'(out_distance_whole_cm) * 32'd10 <= 32'(out_distance_tenth_cm) + 32'd5) && (32'(out_distance_tenth_cm) + 32'd5 < 32'(out_distance_whole_cm) * 32'd10 + 32'd10)), "whole cm rounding wrong")

  // A stalled result stays in place
  `RTID_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_distance_tenth_cm), "stalled result lost")

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI to distance interpolator testbench
// Drives RSSI samples in random bursts against a receiver that stalls on a
// pattern of its own, predicts each distance reading from the calibration
// ROM and checks every reading in order. The far distance register is
// rewritten between phases, its extremes and the saturation point included.
// ----------------------------------------------------------------------------
module tb;
  import rtid_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_TAIL    = 16;
  localparam int PHASES        = 7;
  localparam int PHASE_SAMPLES = 150;

  typedef struct {
    logic [DIST_W-1:0]  tenth_cm;
    logic [WHOLE_W-1:0] whole_cm;
    range_status_t      status;
    logic               in_cal;
  } distance_reading_t;

  // Predict distance readings in order and compare them with the block
  class distance_scoreboard;
    logic [CFG_W-1:0]  far_cm;
    distance_reading_t pending_distances[$];
    int                errors;

    function new();
      far_cm = FAR_CM_RESET;
      errors = 0;
    endfunction

    function void set_far_cm(logic [CFG_W-1:0] v);
      far_cm = v;
    endfunction

    function int pending();
      return pending_distances.size();
    endfunction

    // Walk the segments; the first bracketing one wins
    function int unsigned interpolate(int unsigned x2);
      int unsigned hi, lo, d0, d1, span, q;
      for (int i = 0; i + 1 < TABLE_POINTS; i++) begin
        hi = CAL_ROM[i].rssi;
        lo = CAL_ROM[i + 1].rssi;
        if (x2 <= hi && x2 >= lo) begin
          d0   = CAL_ROM[i].dist_x10;
          d1   = CAL_ROM[i + 1].dist_x10;
          span = hi - lo;
          if (span == 0) return d0;
          q = ((hi - x2) * ((d1 - d0) & 32'hFFFF) + span / 2) / span;
          return (d0 + q) & 32'hFFFF;
        end
      end
      return CAL_ROM[TABLE_POINTS - 1].dist_x10;
    endfunction

    function distance_reading_t compute_distance(logic [RSSI_W-1:0] raw);
      distance_reading_t r;
      logic [RSSI_W-1:0] x2;
      int unsigned dist_val;
      x2 = {raw[RSSI_W-2:0], 1'b0};
      if (x2 > CAL_ROM[0].rssi) begin
        r.status = STATUS_NEAR;
        dist_val = CAL_ROM[0].dist_x10;
      end else if (x2 < CAL_ROM[TABLE_POINTS - 1].rssi) begin
        r.status = STATUS_FAR;
        dist_val = far_cm * 10;
        if (dist_val > 32'hFFFF) dist_val = 32'hFFFF;
      end else begin
        r.status = STATUS_VALID;
        dist_val = interpolate(x2);
      end
      r.tenth_cm = dist_val[DIST_W-1:0];
      r.whole_cm = WHOLE_W'((dist_val + 5) / 10);
      r.in_cal   = (r.status == STATUS_VALID);
      return r;
    endfunction

    function void note_sample(logic [RSSI_W-1:0] raw);
      pending_distances.push_back(compute_distance(raw));
    endfunction

    function void check_reading(logic [DIST_W-1:0] tenth, logic [WHOLE_W-1:0] whole,
                                logic [1:0] status, logic in_cal);
      distance_reading_t e;
      if (pending_distances.size() == 0) begin
        $error("reading with no sample outstanding: tenth_cm %0d", tenth);
        errors++;
        return;
      end
      e = pending_distances.pop_front();
      if (tenth !== e.tenth_cm) begin
        $error("distance_tenth_cm: expected %0d, actual %0d", e.tenth_cm, tenth);
        errors++;
      end
      if (whole !== e.whole_cm) begin
        $error("distance_whole_cm: expected %0d, actual %0d", e.whole_cm, whole);
        errors++;
      end
      if (status !== e.status) begin
        $error("range_status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (in_cal !== e.in_cal) begin
        $error("in_calibration: expected %0d, actual %0d", e.in_cal, in_cal);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [RSSI_W-1:0]   in_rssi_sample;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DIST_W-1:0]   out_distance_tenth_cm;
  logic [WHOLE_W-1:0]  out_distance_whole_cm;
  logic [1:0]          out_range_status;
  logic                out_in_calibration;
  logic                cfg_wr_en;
  logic [CFG_W-1:0]    cfg_wr_data;

  distance_scoreboard  sb;
  int unsigned         cycle_count = 0;
  int unsigned         stall_mode = 0;
  int unsigned         stall_left = 0;

  rssi_to_distance_interpolator_top DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_rssi_sample        (in_rssi_sample),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_distance_tenth_cm (out_distance_tenth_cm),
    .out_distance_whole_cm (out_distance_whole_cm),
    .out_range_status      (out_range_status),
    .out_in_calibration    (out_in_calibration),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stall the result side in randomly chosen modes
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 99) < 70);
      default: out_stall <= ((cycle_count % 5) < 2);
    endcase
  end

  // Track register writes and accepted samples
  always @(posedge clk) begin
    if (rst_n && cfg_wr_en) sb.set_far_cm(cfg_wr_data);
    if (rst_n && in_valid && !in_stall) sb.note_sample(in_rssi_sample);
  end

  // Check each accepted reading
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_reading(out_distance_tenth_cm, out_distance_whole_cm,
                       out_range_status, out_in_calibration);
  end

  // Hold the sample until the block takes it
  task automatic send_sample(input logic [RSSI_W-1:0] v);
    in_valid       <= 1'b1;
    in_rssi_sample <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic write_far_cm(input logic [CFG_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every reading, then let the pipeline settle
  task automatic drain_readings();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Mostly in-table samples, with edges, clamps, wrap aliases and noise
  function automatic logic [RSSI_W-1:0] pick_sample();
    int unsigned r, k;
    logic [RSSI_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      v = RSSI_W'($urandom_range(CAL_ROM[TABLE_POINTS - 1].rssi / 2, CAL_ROM[0].rssi / 2));
    end else if (r < 65) begin
      v = RSSI_W'($urandom_range(CAL_ROM[0].rssi / 2 + 1, 32767));
    end else if (r < 75) begin
      v = RSSI_W'($urandom_range(0, CAL_ROM[TABLE_POINTS - 1].rssi / 2 - 1));
    end else if (r < 85) begin
      k = $urandom_range(0, TABLE_POINTS - 1);
      v = RSSI_W'(CAL_ROM[k].rssi / 2 + $urandom_range(0, 2) - 1);
    end else begin
      v = RSSI_W'($urandom);
    end
    if (r < 85 && $urandom_range(0, 3) == 0) v[RSSI_W-1] = 1'b1;
    return v;
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 20);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_sample(pick_sample());
        sent++;
      end
      if ($urandom_range(0, 9) >= 3) idle_sender($urandom_range(1, 6));
    end
  endtask

  initial begin
    logic [RSSI_W-1:0] directed[$];
    logic [CFG_W-1:0]  far_list[PHASES];

    sb = new();
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_rssi_sample <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Field extremes, both table ends, inner points, clamps and wrap aliases
    directed = '{16'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd2881, 16'd2882, 16'd2880,
                 16'd560, 16'd559, 16'd561, 16'd2512, 16'd2249, 16'd1427, 16'd1000,
                 16'd900, 16'd836, 16'd580, 16'd35649, 16'd33328, 16'd33327,
                 16'd33768, 16'h5555, 16'hAAAA, 16'd1};
    foreach (directed[i]) begin
      send_sample(directed[i]);
      if (i % 5 == 4) idle_sender($urandom_range(1, 3));
    end
    drain_readings();

    far_list = '{13'd0, 13'd8191, 13'd6553, 13'd6554, 13'd1, 13'd0, 13'd0};
    far_list[5] = CFG_W'($urandom_range(0, 8191));
    far_list[6] = CFG_W'($urandom_range(0, 6553));

    // One random phase per far distance setting
    for (int p = 0; p < PHASES; p++) begin
      write_far_cm(far_list[p]);
      run_random(PHASE_SAMPLES);
      drain_readings();
    end

    if (sb.pending() != 0) begin
      $error("%0d readings never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
